// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the nearest neighbor scaler.
// They expect a clock named clock and an active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define NNIS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define NNIS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/nnis_pkg.sv =====
// Package for the nearest neighbor image scaler: widths, codes and shared types.
// Used by nnis_raster and the top level nearest_neighbor_image_scaler_unit.
`default_nettype none

package nnis_pkg;

   localparam int PIXEL_BITS       = 32;
   localparam int FACTOR_FRAC_BITS = 8;
   localparam int FACTOR_BITS      = 16;
   localparam int DIM_REG_BITS     = 9;
   localparam int POS_BITS         = 16;
   localparam int ACC_BITS         = POS_BITS + FACTOR_FRAC_BITS;
   localparam int STEP_BITS        = FACTOR_FRAC_BITS + 1;
   localparam int STORE_ADDR_BITS  = 16;
   localparam int STORE_DEPTH      = 1 << STORE_ADDR_BITS;
   localparam int MAX_DIM_DEFAULT  = 256;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 16;
   localparam int REQ_DATA_BITS    = 32;
   localparam int RSP_DATA_BITS    = 64;

   localparam logic [POS_BITS-1:0] OUT_DIM_MAX = '1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_FACTOR  = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   typedef struct packed {
      logic [POS_BITS-1:0] col;
      logic [POS_BITS-1:0] row;
      logic                last;
   } pos_info_type;

   typedef struct packed {
      logic step;
      logic clear;
   } raster_ctl_type;

   typedef struct packed {
      logic [POS_BITS-1:0]    pos;
      logic [ACC_BITS-1:0]    acc;
      logic [FACTOR_BITS-1:0] rem;
   } axis_type;

endpackage

`default_nettype wire

// ===== hw/rtl/nnis_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module nnis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/nnis_div.sv =====
// Restoring divider, one quotient bit per cycle, for the scaler's coordinate setup.
// No dependencies.
`default_nettype none

module nnis_div #(
   parameter int DIVIDEND_BITS = 24,
   parameter int DIVISOR_BITS  = 16,
   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [DIVIDEND_BITS-1:0] dividend,
   input  wire logic [DIVISOR_BITS-1:0]  divisor,
   output logic                          done,
   output logic      [DIVIDEND_BITS-1:0] quotient,
   output logic      [DIVISOR_BITS-1:0]  remainder
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [DIVIDEND_BITS-1:0] work_ff, work_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_BITS:0]    trial;
   logic                     qbit;

   always_comb begin
      trial      = {rem_ff, work_ff[DIVIDEND_BITS-1]};
      qbit       = (trial >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_BITS'(DIVIDEND_BITS);
         work_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         work_in  = {work_ff[DIVIDEND_BITS-2:0], qbit};
         rem_in   = qbit ? DIVISOR_BITS'(trial - {1'b0, divisor_ff})
                         : trial[DIVISOR_BITS-1:0];
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/nnis_raster.sv =====
// Configuration registers, output raster position and incremental source mapping.
// Depends on nnis_pkg and nnis_div.
`default_nettype none

module nnis_raster #(
   parameter int MAX_DIM = nnis_pkg::MAX_DIM_DEFAULT,
   localparam int DIM_BITS = $clog2(MAX_DIM + 1),
   localparam int IDX_BITS = $clog2(MAX_DIM)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [nnis_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [nnis_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire nnis_pkg::raster_ctl_type            ctl,
   output logic                                     busy,
   output logic      [DIM_BITS-1:0]                 src_width,
   output nnis_pkg::pos_info_type                   pos,
   output logic      [IDX_BITS-1:0]                 src_col,
   output logic      [IDX_BITS-1:0]                 src_row
);

   localparam int PROD_BITS = DIM_BITS + nnis_pkg::FACTOR_BITS;

   typedef enum logic [3:0] {
      SQ_IDLE = 4'b0001,
      SQ_STEP = 4'b0010,
      SQ_COL  = 4'b0100,
      SQ_ROW  = 4'b1000
   } seq_state_type;

   seq_state_type seq_ff, seq_in;
   logic          launch_ff, launch_in;

   logic [nnis_pkg::DIM_REG_BITS-1:0] src_w_ff, src_w_in;
   logic [nnis_pkg::DIM_REG_BITS-1:0] src_h_ff, src_h_in;
   logic [nnis_pkg::FACTOR_BITS-1:0]  factor_ff, factor_in;

   nnis_pkg::axis_type x_ff, x_in;
   nnis_pkg::axis_type y_ff, y_in;
   nnis_pkg::axis_type cur_x, cur_y;

   logic [nnis_pkg::STEP_BITS-1:0]   q0_ff, q0_in;
   logic [nnis_pkg::FACTOR_BITS-1:0] r0_ff, r0_in;

   logic [DIM_BITS-1:0]              w_eff_ff, h_eff_ff;
   logic [nnis_pkg::POS_BITS-1:0]    ow_ff, oh_ff;
   logic [nnis_pkg::FACTOR_BITS-1:0] f_eff;
   logic [DIM_BITS-1:0]              w_now, h_now;

   logic [nnis_pkg::ACC_BITS-1:0]    div_dividend;
   logic                             div_done;
   logic [nnis_pkg::ACC_BITS-1:0]    div_quo;
   logic [nnis_pkg::FACTOR_BITS-1:0] div_rem;

   logic restart, col_more, row_more;

   function automatic logic [DIM_BITS-1:0] clamp_dim(
      input logic [nnis_pkg::DIM_REG_BITS-1:0] v
   );
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = DIM_BITS'(v);
      end
      return r;
   endfunction

   function automatic logic [nnis_pkg::POS_BITS-1:0] out_size(
      input logic [DIM_BITS-1:0]              dim,
      input logic [nnis_pkg::FACTOR_BITS-1:0] f
   );
      logic [PROD_BITS-1:0]          prod;
      logic [nnis_pkg::POS_BITS-1:0] r;
      prod = (PROD_BITS'(dim) * PROD_BITS'(f)) >> nnis_pkg::FACTOR_FRAC_BITS;
      if (prod == '0) begin
         r = nnis_pkg::POS_BITS'(1);
      end else if (prod > PROD_BITS'(nnis_pkg::OUT_DIM_MAX)) begin
         r = nnis_pkg::OUT_DIM_MAX;
      end else begin
         r = nnis_pkg::POS_BITS'(prod);
      end
      return r;
   endfunction

   function automatic logic [IDX_BITS-1:0] clamp_index(
      input logic [nnis_pkg::ACC_BITS-1:0] acc,
      input logic [DIM_BITS-1:0]           dim
   );
      logic [DIM_BITS-1:0] limit;
      logic [IDX_BITS-1:0] r;
      limit = dim - DIM_BITS'(1);
      if (acc > nnis_pkg::ACC_BITS'(limit)) begin
         r = IDX_BITS'(limit);
      end else begin
         r = IDX_BITS'(acc);
      end
      return r;
   endfunction

   function automatic nnis_pkg::axis_type advance(
      input nnis_pkg::axis_type               cur,
      input logic [nnis_pkg::STEP_BITS-1:0]   q,
      input logic [nnis_pkg::FACTOR_BITS-1:0] r,
      input logic [nnis_pkg::FACTOR_BITS-1:0] f
   );
      nnis_pkg::axis_type             nxt;
      logic [nnis_pkg::FACTOR_BITS:0] sum;
      sum     = {1'b0, cur.rem} + {1'b0, r};
      nxt.pos = cur.pos + nnis_pkg::POS_BITS'(1);
      nxt.acc = cur.acc + nnis_pkg::ACC_BITS'(q);
      if (sum >= {1'b0, f}) begin
         nxt.rem = nnis_pkg::FACTOR_BITS'(sum - {1'b0, f});
         nxt.acc = nxt.acc + nnis_pkg::ACC_BITS'(1);
      end else begin
         nxt.rem = sum[nnis_pkg::FACTOR_BITS-1:0];
      end
      return nxt;
   endfunction

   assign f_eff = (factor_ff == '0) ? nnis_pkg::FACTOR_BITS'(1) : factor_ff;
   assign w_now = clamp_dim(src_w_ff);
   assign h_now = clamp_dim(src_h_ff);

   always_ff @(posedge clock) begin
      w_eff_ff <= w_now;
      h_eff_ff <= h_now;
      ow_ff    <= out_size(w_now, f_eff);
      oh_ff    <= out_size(h_now, f_eff);
   end

   always_comb begin
      unique case (seq_ff)
         SQ_STEP: div_dividend = nnis_pkg::ACC_BITS'(1) << nnis_pkg::FACTOR_FRAC_BITS;
         SQ_COL:  div_dividend = {x_ff.pos, {nnis_pkg::FACTOR_FRAC_BITS{1'b0}}};
         SQ_ROW:  div_dividend = {y_ff.pos, {nnis_pkg::FACTOR_FRAC_BITS{1'b0}}};
         default: div_dividend = '0;
      endcase
   end

   nnis_div #(
      .DIVIDEND_BITS(nnis_pkg::ACC_BITS),
      .DIVISOR_BITS (nnis_pkg::FACTOR_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (launch_ff),
      .dividend (div_dividend),
      .divisor  (f_eff),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // A position left outside a shrunken frame restarts the raster at the origin.
   assign restart  = (x_ff.pos >= ow_ff) || (y_ff.pos >= oh_ff);
   assign cur_x    = restart ? '0 : x_ff;
   assign cur_y    = restart ? '0 : y_ff;
   assign col_more = ({1'b0, cur_x.pos} + 17'd1) < {1'b0, ow_ff};
   assign row_more = ({1'b0, cur_y.pos} + 17'd1) < {1'b0, oh_ff};

   always_comb begin
      seq_in    = seq_ff;
      launch_in = 1'b0;
      src_w_in  = src_w_ff;
      src_h_in  = src_h_ff;
      factor_in = factor_ff;
      q0_in     = q0_ff;
      r0_in     = r0_ff;
      x_in      = x_ff;
      y_in      = y_ff;

      if (csr_we) begin
         unique case (csr_index)
            nnis_pkg::CSR_SOURCE_WIDTH:
               src_w_in = csr_wdata[nnis_pkg::DIM_REG_BITS-1:0];
            nnis_pkg::CSR_SOURCE_HEIGHT:
               src_h_in = csr_wdata[nnis_pkg::DIM_REG_BITS-1:0];
            nnis_pkg::CSR_SCALE_FACTOR:
               factor_in = csr_wdata[nnis_pkg::FACTOR_BITS-1:0];
            default: ;
         endcase
         seq_in    = SQ_STEP;
         launch_in = 1'b1;
      end else if (div_done) begin
         unique case (seq_ff)
            SQ_STEP: begin
               q0_in     = nnis_pkg::STEP_BITS'(div_quo);
               r0_in     = div_rem;
               seq_in    = SQ_COL;
               launch_in = 1'b1;
            end
            SQ_COL: begin
               x_in.acc  = div_quo;
               x_in.rem  = div_rem;
               seq_in    = SQ_ROW;
               launch_in = 1'b1;
            end
            SQ_ROW: begin
               y_in.acc = div_quo;
               y_in.rem = div_rem;
               seq_in   = SQ_IDLE;
            end
            default: ;
         endcase
      end

      if (ctl.clear) begin
         x_in = '0;
         y_in = '0;
      end else if (ctl.step) begin
         if (col_more) begin
            x_in = advance(cur_x, q0_ff, r0_ff, f_eff);
            y_in = cur_y;
         end else begin
            x_in = '0;
            y_in = row_more ? advance(cur_y, q0_ff, r0_ff, f_eff) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= SQ_STEP;
         launch_ff <= 1'b1;
         src_w_ff  <= nnis_pkg::DIM_REG_BITS'(1);
         src_h_ff  <= nnis_pkg::DIM_REG_BITS'(1);
         factor_ff <= nnis_pkg::FACTOR_BITS'(1) << nnis_pkg::FACTOR_FRAC_BITS;
         x_ff      <= '0;
         y_ff      <= '0;
      end else begin
         seq_ff    <= seq_in;
         launch_ff <= launch_in;
         src_w_ff  <= src_w_in;
         src_h_ff  <= src_h_in;
         factor_ff <= factor_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      r0_ff <= r0_in;
   end

   assign busy      = (seq_ff != SQ_IDLE);
   assign src_width = w_eff_ff;
   assign pos.col   = cur_x.pos;
   assign pos.row   = cur_y.pos;
   assign pos.last  = (cur_x.pos == ow_ff - nnis_pkg::POS_BITS'(1))
                   && (cur_y.pos == oh_ff - nnis_pkg::POS_BITS'(1));
   assign src_col   = clamp_index(cur_x.acc, w_eff_ff);
   assign src_row   = clamp_index(cur_y.acc, h_eff_ff);

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_neighbor_image_scaler_unit.sv =====
// Fetch: the request registers the source position, ST_ADDR reads the store, and ST_DATA
// registers the result when the output can take it; new requests wait until it is taken.
// Loads: one per cycle while no fetch is in flight. Every register write, and reset, reruns
// the coordinate setup on the serial divider; requests wait until it is done.
// Reset is synchronous and clears control state; the frame store holds old contents.
// Depends on nnis_pkg, nnis_raster, nnis_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nearest_neighbor_image_scaler_unit #(
   parameter int MAX_DIM = nnis_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request stream.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [nnis_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // [31:0] pixel_in
   input  wire logic                                req_tuser,  // [0] req_type
   // Response stream.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [nnis_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // [31:0] pixel_out,
                                                                // [47:32] out_col,
                                                                // [63:48] out_row
   output logic                                     rsp_tlast,  // frame_last
   // Register writes.
   input  wire logic                                csr_we,
   input  wire logic [nnis_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [nnis_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int DIM_BITS = $clog2(MAX_DIM + 1);
   localparam int IDX_BITS = $clog2(MAX_DIM);
   localparam int LIN_BITS = IDX_BITS + DIM_BITS + 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADDR = 3'b010,
      ST_DATA = 3'b100
   } fsm_state_type;

   fsm_state_type state_ff, state_in;

   logic                                   emitting_ff, emitting_in;
   logic [nnis_pkg::STORE_ADDR_BITS-1:0]   load_pos_ff, load_pos_in;
   logic [nnis_pkg::STORE_ADDR_BITS-1:0]   load_base;

   nnis_pkg::pos_info_type                 pend_ff, pend_in;
   logic [IDX_BITS-1:0]                    sx_ff, sx_in, sy_ff, sy_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [nnis_pkg::PIXEL_BITS-1:0]        pixel_ff, pixel_in;
   nnis_pkg::pos_info_type                 out_ff, out_in;

   nnis_pkg::raster_ctl_type               ctl;
   nnis_pkg::pos_info_type                 pos;
   logic                                   seq_busy;
   logic [DIM_BITS-1:0]                    src_width;
   logic [IDX_BITS-1:0]                    src_col, src_row;

   logic                                   req_fire, is_fetch, capture;
   logic                                   ram_we, ram_re;
   logic [LIN_BITS-1:0]                    lin;
   logic [nnis_pkg::STORE_ADDR_BITS-1:0]   ram_raddr;
   logic [nnis_pkg::PIXEL_BITS-1:0]        ram_rdata;

   assign capture    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !seq_busy
                    && ((state_ff == ST_IDLE) || ((state_ff == ST_DATA) && capture));
   assign req_fire   = req_tvalid && req_tready;
   assign is_fetch   = (req_tuser == nnis_pkg::REQ_FETCH);

   assign ctl.step  = req_fire && is_fetch;
   assign ctl.clear = req_fire && (req_tuser == nnis_pkg::REQ_LOAD) && emitting_ff;

   nnis_raster #(
      .MAX_DIM(MAX_DIM)
   ) u_raster (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .ctl      (ctl),
      .busy     (seq_busy),
      .src_width(src_width),
      .pos      (pos),
      .src_col  (src_col),
      .src_row  (src_row)
   );

   // A load that follows fetches starts a new image at store index zero.
   assign load_base = emitting_ff ? '0 : load_pos_ff;
   assign ram_we    = req_fire && (req_tuser == nnis_pkg::REQ_LOAD);
   assign ram_re    = (state_ff == ST_ADDR);
   assign lin       = LIN_BITS'(sy_ff) * LIN_BITS'(src_width) + LIN_BITS'(sx_ff);
   assign ram_raddr = nnis_pkg::STORE_ADDR_BITS'(lin);

   nnis_ram #(
      .WIDTH(nnis_pkg::PIXEL_BITS),
      .DEPTH(nnis_pkg::STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(load_base),
      .wr_data(req_tdata[nnis_pkg::PIXEL_BITS-1:0]),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      emitting_in  = emitting_ff;
      load_pos_in  = load_pos_ff;
      pend_in      = pend_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      rsp_valid_in = rsp_valid_ff;
      pixel_in     = pixel_ff;
      out_in       = out_ff;

      if (req_fire) begin
         emitting_in = is_fetch;
         if (is_fetch) begin
            pend_in = pos;
            sx_in   = src_col;
            sy_in   = src_row;
         end else begin
            load_pos_in = load_base + nnis_pkg::STORE_ADDR_BITS'(1);
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.step) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (capture) begin
               rsp_valid_in = 1'b1;
               pixel_in     = ram_rdata;
               out_in       = pend_ff;
               state_in     = ctl.step ? ST_ADDR : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         emitting_ff  <= 1'b0;
         load_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         emitting_ff  <= emitting_in;
         load_pos_ff  <= load_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff  <= pend_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      pixel_ff <= pixel_in;
      out_ff   <= out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_ff.row, out_ff.col, pixel_ff};
   assign rsp_tlast  = out_ff.last;

   `NNIS_ASSERT_NEXT(a_csr_holds_requests, csr_we, !req_tready, "request accepted during setup")
   `NNIS_ASSERT_NEXT(a_addr_then_data, state_ff == ST_ADDR, state_ff == ST_DATA, "read not completed")
   `NNIS_ASSERT_NEXT(a_capture_shows, (state_ff == ST_DATA) && capture, rsp_tvalid, "result lost")
   `NNIS_ASSERT_NOW(a_no_read_write_overlap, ram_re, !ram_we, "store read and written together")

endmodule

`default_nettype wire
